>>> rtl/itd_pkg.sv
// Shared constants for the signed integer to decimal text converter.
package itd_pkg;

    localparam int unsigned VALUE_BITS_DEF = 32;

    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_MINUS = 8'd45;

    // Magnitude bits consumed per double-dabble step.
    localparam int unsigned DD_BITS = 4;

    // BCD add-3 correction threshold.
    localparam logic [3:0] DD_LIMIT = 4'd5;
    localparam logic [3:0] DD_ADJ   = 4'd3;

endpackage

>>> rtl/itd_front.sv
// Front end: request intake, sign/magnitude split and a two-entry queue.
module itd_front #(
    parameter int unsigned VALUE_BITS = itd_pkg::VALUE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  q_valid,
    input  logic                  q_pop,
    output logic                  q_neg,
    output logic [VALUE_BITS-1:0] q_mag
);
    import itd_pkg::*;

    logic                  neg_reg [2];
    logic [VALUE_BITS-1:0] mag_reg [2];
    logic                  wr_ptr_reg, wr_ptr_next;
    logic                  rd_ptr_reg, rd_ptr_next;
    logic [1:0]            count_reg, count_next;
    logic                  push;
    logic                  in_neg;
    logic [VALUE_BITS-1:0] in_mag;

    // Magnitude in unsigned arithmetic: the most negative value maps onto itself.
    assign in_neg = value[VALUE_BITS-1];
    assign in_mag = in_neg ? (~value + VALUE_BITS'(1)) : value;

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_neg    = neg_reg[rd_ptr_reg];
    assign q_mag    = mag_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            neg_reg[wr_ptr_reg] <= in_neg;
            mag_reg[wr_ptr_reg] <= in_mag;
        end
    end

endmodule

>>> rtl/itd_conv.sv
// Iterative binary to BCD conversion, four magnitude bits per cycle.
module itd_conv #(
    parameter int unsigned VALUE_BITS = itd_pkg::VALUE_BITS_DEF,
    localparam int unsigned STEPS = (VALUE_BITS + itd_pkg::DD_BITS - 1) / itd_pkg::DD_BITS,
    localparam int unsigned PAD   = STEPS * itd_pkg::DD_BITS,
    localparam int unsigned ND    = ((VALUE_BITS - 1) * 30103) / 100000 + 1,
    localparam int unsigned IDXW  = $clog2(ND),
    localparam int unsigned CNTW  = $clog2(STEPS)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  logic                  q_neg,
    input  logic [VALUE_BITS-1:0] q_mag,
    output logic                  res_valid,
    input  logic                  res_take,
    output logic                  res_neg,
    output logic [ND*4-1:0]       res_bcd,
    output logic [IDXW-1:0]       res_lead
);
    import itd_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNTW-1:0]   cnt_reg, cnt_next;
    logic [PAD-1:0]    mag_reg, mag_next;
    logic [ND*4-1:0]   bcd_reg, bcd_next;
    logic              neg_reg;
    logic              last_step;

    assign q_pop     = q_valid && !busy_reg && !done_reg;
    assign last_step = (cnt_reg == CNTW'(STEPS - 1));
    assign res_valid = done_reg;
    assign res_neg   = neg_reg;
    assign res_bcd   = bcd_reg;

    // DD_BITS shift-and-adjust passes per cycle
    always_comb
    begin
        logic [ND*4-1:0] b;
        logic [PAD-1:0]  m;
        b = bcd_reg;
        m = mag_reg;
        for (int s = 0; s < DD_BITS; s++)
        begin
            for (int d = 0; d < ND; d++)
            begin
                if (b[d*4 +: 4] >= DD_LIMIT)
                    b[d*4 +: 4] = b[d*4 +: 4] + DD_ADJ;
            end
            b = {b[ND*4-2:0], m[PAD-1]};
            m = {m[PAD-2:0], 1'b0};
        end
        bcd_next = b;
        mag_next = m;
    end

    // position of the leading nonzero digit, zero when the value is zero
    always_comb
    begin
        res_lead = '0;
        for (int d = 0; d < ND; d++)
        begin
            if (bcd_reg[d*4 +: 4] != 4'd0)
                res_lead = IDXW'(d);
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        if (q_pop)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + CNTW'(1);
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        if (done_reg && res_take)
            done_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            mag_reg <= PAD'(q_mag);
            bcd_reg <= '0;
            neg_reg <= q_neg;
        end
        else if (busy_reg)
        begin
            mag_reg <= mag_next;
            bcd_reg <= bcd_next;
        end
    end

`ifndef SYNTHESIS
    a_busy_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && done_reg))
        else $error("converter busy and done together");

    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && last_step |=> done_reg && !busy_reg)
        else $error("conversion did not complete after final step");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !busy_reg && !done_reg)
        else $error("queue popped while converter occupied");
`endif

endmodule

>>> rtl/itd_emit.sv
// Character emitter: sign, then digits from the leading one down, into an output register.
module itd_emit #(
    parameter int unsigned VALUE_BITS = itd_pkg::VALUE_BITS_DEF,
    localparam int unsigned ND   = ((VALUE_BITS - 1) * 30103) / 100000 + 1,
    localparam int unsigned IDXW = $clog2(ND)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            res_valid,
    output logic            res_take,
    input  logic            res_neg,
    input  logic [ND*4-1:0] res_bcd,
    input  logic [IDXW-1:0] res_lead,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      text_char,
    output logic            last_char
);
    import itd_pkg::*;

    logic            busy_reg;
    logic            pend_reg;
    logic [IDXW-1:0] idx_reg;
    logic [ND*4-1:0] bcd_reg;
    logic            out_valid_reg;
    logic [7:0]      char_reg;
    logic            last_reg;
    logic            fire;
    logic [3:0]      digit;
    logic [7:0]      char_next;
    logic            last_next;

    assign res_take = res_valid && !busy_reg;
    assign fire     = busy_reg && (!out_valid_reg || out_ready);
    assign digit    = bcd_reg[idx_reg*4 +: 4];

    always_comb
    begin
        char_next = pend_reg ? ASCII_MINUS : (ASCII_ZERO + {4'd0, digit});
        last_next = !pend_reg && (idx_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_take)
            begin
                busy_reg <= 1'b1;
                pend_reg <= res_neg;
            end
            else if (fire)
            begin
                if (pend_reg)
                    pend_reg <= 1'b0;
                else if (idx_reg == '0)
                    busy_reg <= 1'b0;
            end

            if (fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            idx_reg <= res_lead;
            bcd_reg <= res_bcd;
        end
        else if (fire && !pend_reg && (idx_reg != '0))
        begin
            idx_reg <= idx_reg - IDXW'(1);
        end

        if (fire)
        begin
            char_reg <= char_next;
            last_reg <= last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign text_char = char_reg;
    assign last_char = last_reg;

`ifndef SYNTHESIS
    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (char_reg == ASCII_MINUS) |-> !last_reg)
        else $error("minus sign flagged as final character");

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (char_reg != ASCII_MINUS) |->
            (char_reg >= ASCII_ZERO) && (char_reg <= ASCII_ZERO + 8'd9))
        else $error("character outside digit range");

    a_pend_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> busy_reg)
        else $error("sign pending outside a run");
`endif

endmodule

>>> rtl/signed_int_to_decimal_ascii_core.sv
// Top level of the signed integer to decimal ASCII converter.
//
//  channel | signals                              | moves
//  --------+--------------------------------------+---------------------------------
//  in      | in_valid, in_ready, value            | one signed integer per request
//  out     | out_valid, out_ready, text_char,     | one ASCII character per request,
//          | last_char                            | last_char on the final one
//
// A request waits in the queue, is converted in the double-dabble converter and is
// then handed off to the emitter, which sends its characters in turn. Conversion
// of the next request overlaps emission of the current one. rst_n clears all control
// state; no clearing pass. out_ready low holds the output register; the queue then
// fills and drops in_ready.
module signed_int_to_decimal_ascii_core #(
    parameter int unsigned VALUE_BITS = itd_pkg::VALUE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [VALUE_BITS-1:0] value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [7:0]                   text_char,
    output logic                         last_char
);
    import itd_pkg::*;

    localparam int unsigned ND   = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
    localparam int unsigned IDXW = $clog2(ND);

    logic                  q_valid;
    logic                  q_pop;
    logic                  q_neg;
    logic [VALUE_BITS-1:0] q_mag;
    logic                  res_valid;
    logic                  res_take;
    logic                  res_neg;
    logic [ND*4-1:0]       res_bcd;
    logic [IDXW-1:0]       res_lead;

    itd_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .value    (value),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_neg    (q_neg),
        .q_mag    (q_mag)
    );

    itd_conv #(
        .VALUE_BITS (VALUE_BITS)
    ) u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_neg     (q_neg),
        .q_mag     (q_mag),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res_neg   (res_neg),
        .res_bcd   (res_bcd),
        .res_lead  (res_lead)
    );

    itd_emit #(
        .VALUE_BITS (VALUE_BITS)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res_neg   (res_neg),
        .res_bcd   (res_bcd),
        .res_lead  (res_lead),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .text_char (text_char),
        .last_char (last_char)
    );

endmodule

>>> tb/signed_int_to_decimal_ascii_core_test.sv
// Self-checking testbench for the signed integer to decimal ASCII converter.
module signed_int_to_decimal_ascii_core_test;

    import itd_pkg::*;

    localparam int VB          = VALUE_BITS_DEF;
    localparam int RANDOM_NUMS = 220;
    localparam int QUIET_TAIL  = 30;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic [VB-1:0] num;
        bit            drain;   // hold this request until all text is out
    } num_req_t;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } text_out_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            in_valid = 1'b0;
    logic            in_ready;
    logic [VB-1:0]   value = '0;
    logic            out_valid;
    logic            out_ready = 1'b0;
    logic [7:0]      text_char;
    logic            last_char;

    num_req_t        num_queue[$];
    text_out_t       text_expected[$];
    logic            in_taken = 1'b0;
    int              gap_left = 0;
    int              stall_left = 0;
    int              errors = 0;
    int              cycles = 0;

    signed_int_to_decimal_ascii_core #(
        .VALUE_BITS(VB)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .value    (value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .text_char(text_char),
        .last_char(last_char)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Queue the decimal text of one number, sign first, most significant digit first.
    function automatic void spell_decimal(input logic [VB-1:0] num);
        logic [VB-1:0] mag;
        logic [3:0]    digits[$];
        text_out_t     t;
        mag = num[VB-1] ? (~num + 1'b1) : num;
        do
        begin
            digits.push_front(4'(mag % 10));
            mag = mag / 10;
        end
        while (mag != 0);
        if (num[VB-1])
        begin
            t.ch   = ASCII_MINUS;
            t.last = 1'b0;
            text_expected.push_back(t);
        end
        while (digits.size() > 0)
        begin
            t.ch   = ASCII_ZERO + 8'(digits.pop_front());
            t.last = (digits.size() == 0);
            text_expected.push_back(t);
        end
    endfunction

    function automatic logic [VB-1:0] random_number();
        logic [VB-1:0] num;
        longint        lim;
        int            k;
        case ($urandom_range(0, 3))
            0:
            begin
                num = $urandom();
            end
            1, 2:
            begin
                // pick a digit count first so short and long runs both show up
                k   = $urandom_range(1, 10);
                lim = 1;
                repeat (k) lim = lim * 10;
                lim = lim - 1;
                if (lim > 64'd2147483647)
                    lim = 64'd2147483647;
                num = $urandom_range(0, int'(lim));
                if ($urandom_range(0, 1))
                    num = -num;
            end
            default:
            begin
                case ($urandom_range(0, 2))
                    0: num = 32'h7fffffff - $urandom_range(0, 20);
                    1: num = 32'h80000000 + $urandom_range(0, 20);
                    default: num = $urandom_range(0, 40) - 20;
                endcase
            end
        endcase
        return num;
    endfunction

    function automatic void add_num(input logic [VB-1:0] num, input bit drain);
        num_req_t r;
        r.num   = num;
        r.drain = drain;
        num_queue.push_back(r);
    endfunction

    // Driver: requests and output stalls change on the falling edge.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            out_ready <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_taken)
            begin
                // request still pending, hold it
            end
            else if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left = gap_left - 1;
            end
            else if (num_queue.size() == 0)
            begin
                in_valid <= 1'b0;
            end
            else if (num_queue[0].drain && text_expected.size() > 0)
            begin
                in_valid <= 1'b0;
            end
            else if (num_queue.size() > QUIET_TAIL && $urandom_range(0, 5) == 0)
            begin
                gap_left = $urandom_range(1, 7) - 1;
                in_valid <= 1'b0;
            end
            else
            begin
                value    <= num_queue[0].num;
                in_valid <= 1'b1;
                void'(num_queue.pop_front());
            end

            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left = stall_left - 1;
            end
            else if (num_queue.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 7) - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Predict on each accepted request, then check each accepted character.
    always @(posedge clk)
    begin
        text_out_t t;
        in_taken <= in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
            spell_decimal(value);
        if (rst_n && out_valid && out_ready)
        begin
            if (text_expected.size() == 0)
            begin
                $display("%0t: unexpected character: expected none, actual char %0d last %0b",
                         $time, text_char, last_char);
                errors++;
            end
            else
            begin
                t = text_expected.pop_front();
                if (text_char !== t.ch)
                begin
                    $display("%0t: text_char mismatch: expected %0d, actual %0d",
                             $time, t.ch, text_char);
                    errors++;
                end
                if (last_char !== t.last)
                begin
                    $display("%0t: last_char mismatch: expected %0b, actual %0b",
                             $time, t.last, last_char);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("signed_int_to_decimal_ascii_core_test: FAIL");
            $finish;
        end
    end

    initial
    begin
        // directed: zero, single digits, decade edges, both extremes
        add_num(32'd0, 1'b0);
        add_num(32'd1, 1'b0);
        add_num(-32'd1, 1'b0);
        add_num(32'd9, 1'b0);
        add_num(32'd10, 1'b0);
        add_num(-32'd10, 1'b0);
        add_num(32'd99, 1'b0);
        add_num(32'd100, 1'b0);
        add_num(32'd5, 1'b0);
        add_num(-32'd5, 1'b0);
        add_num(32'h7fffffff, 1'b1);
        add_num(32'h80000000, 1'b0);
        add_num(32'h80000001, 1'b0);
        add_num(32'd999999999, 1'b0);
        add_num(32'd1000000000, 1'b0);
        add_num(-32'd999999999, 1'b0);
        add_num(-32'd1000000000, 1'b0);
        add_num(32'd123456789, 1'b0);
        add_num(-32'd2000000000, 1'b0);
        add_num(32'd1999999999, 1'b0);
        add_num(32'h55555555, 1'b0);
        add_num(32'haaaaaaaa, 1'b0);
        for (int i = 0; i < RANDOM_NUMS; i++)
            add_num(random_number(), (i == 0) || ($urandom_range(0, 39) == 0));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (num_queue.size() == 0 && !in_valid);
        wait (text_expected.size() == 0);
        repeat (30) @(posedge clk);
        if (text_expected.size() != 0)
        begin
            $display("%0t: %0d characters never arrived", $time, text_expected.size());
            errors++;
        end
        if (errors == 0)
            $display("signed_int_to_decimal_ascii_core_test: PASS");
        else
            $display("signed_int_to_decimal_ascii_core_test: FAIL");
        $finish;
    end

endmodule

>>> filelist.f
rtl/itd_pkg.sv
rtl/itd_front.sv
rtl/itd_conv.sv
rtl/itd_emit.sv
rtl/signed_int_to_decimal_ascii_core.sv
tb/signed_int_to_decimal_ascii_core_test.sv
